// ===== src/dda_line_rasterizer_assert.svh =====
// ----------------------------------------------------------------------------
// dda line rasterizer assertion macros
// concurrent checks that compile away when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef DDA_LINE_RASTERIZER_ASSERT_SVH
`define DDA_LINE_RASTERIZER_ASSERT_SVH

`ifndef SYNTH
// check a property on every clock edge outside of reset
`define DDA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// check a property on every clock edge, reset included
`define DDA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define DDA_ASSERT(label, clk, rst, prop, msg)
`define DDA_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== src/dda_pkg.sv =====
// ----------------------------------------------------------------------------
// dda line rasterizer package
// default coordinate and fraction widths and request codes shared by the interfaces and the rasterizer
// ----------------------------------------------------------------------------
package dda_pkg;

   // integer coordinate width of endpoints and pixels
   localparam int COORD_BITS = 12;
   // fraction bits of the fixed point position and increments
   localparam int FRAC_BITS = 16;

   // request function codes
   typedef enum logic {FUNC_LOAD = 1'b0, FUNC_ADVANCE = 1'b1} func_type;

endpackage

// ===== src/dda_if.sv =====
// ----------------------------------------------------------------------------
// dda line rasterizer channels
// valid/ready channels for request and pixel response transactions
// ----------------------------------------------------------------------------

// request channel: load endpoints or advance one pixel
interface dda_req_if #(parameter int CoordBits = dda_pkg::COORD_BITS);
   logic                        valid;
   logic                        ready;
   logic                        func;
   logic signed [CoordBits-1:0] x_start;
   logic signed [CoordBits-1:0] y_start;
   logic signed [CoordBits-1:0] x_end;
   logic signed [CoordBits-1:0] y_end;

   modport source (output valid, func, x_start, y_start, x_end, y_end, input ready);
   modport sink   (input valid, func, x_start, y_start, x_end, y_end, output ready);
endinterface

// response channel: one rasterized pixel
interface dda_rsp_if #(parameter int CoordBits = dda_pkg::COORD_BITS);
   logic                        valid;
   logic                        ready;
   logic signed [CoordBits-1:0] pixel_x;
   logic signed [CoordBits-1:0] pixel_y;
   logic                        last;

   modport source (output valid, pixel_x, pixel_y, last, input ready);
   modport sink   (input valid, pixel_x, pixel_y, last, output ready);
endinterface

// ===== src/dda_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// dda line rasterizer
// fixed point digital differential analyzer producing one pixel per load and per advance
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries transactions with func = 0 (load endpoints) or func = 1
//   (advance). A load computes steps = max(|dx|, |dy|) and the two Q.FRAC_BITS
//   increments with one shared restoring divider, one quotient bit per cycle,
//   x first then y, then places the first pixel once the output register is
//   free; req_chan.ready stays low from the accepting edge through the x and
//   y divides until that first pixel is registered. An advance's pixel is
//   registered at the accepting edge, so advances stream one pixel per cycle
//   while the receiver does not stall rsp_chan.
//   An advance with no active line gives no response. A line gives steps+1
//   pixels and last marks the final one.
//   rsp_chan is a single output register: while it holds a pixel that the
//   receiver stalls, no new transaction is taken on req_chan.
//   Reset clears the line state: no line is active and no response is pending.
// ----------------------------------------------------------------------------
`include "dda_line_rasterizer_assert.svh"

module dda_line_rasterizer #(
   parameter int COORD_BITS = dda_pkg::COORD_BITS,
   parameter int FRAC_BITS  = dda_pkg::FRAC_BITS
) (
   input  logic             clock,
   input  logic             reset,
   dda_req_if.sink          req_chan,
   dda_rsp_if.source        rsp_chan
);
   import dda_pkg::*;

   localparam int AW = COORD_BITS + FRAC_BITS + 1;  // accumulator width
   localparam int SW = FRAC_BITS + 2;                // increment width
   localparam int QW = FRAC_BITS + 1;                // quotient magnitude width
   localparam int CW = $clog2(FRAC_BITS + 1);        // divide step counter width
   localparam logic [CW-1:0] CNT_LAST = CW'(FRAC_BITS);

   // sequencer codes
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   // registers
   logic [1:0]                  state_ff, state_in;
   logic signed [AW-1:0]        x_accum_ff, x_accum_in;
   logic signed [AW-1:0]        y_accum_ff, y_accum_in;
   logic signed [SW-1:0]        x_step_ff, x_step_in;
   logic signed [SW-1:0]        y_step_ff, y_step_in;
   logic [COORD_BITS:0]         pixels_left_ff, pixels_left_in;
   logic                        line_active_ff, line_active_in;
   logic [COORD_BITS-1:0]       steps_ff, steps_in;
   logic [COORD_BITS-1:0]       ady_ff, ady_in;
   logic                        x_neg_ff, x_neg_in;
   logic                        y_neg_ff, y_neg_in;
   logic                        axis_ff, axis_in;
   logic [CW-1:0]               cnt_ff, cnt_in;
   logic [COORD_BITS-1:0]       rem_ff, rem_in;
   logic [QW-1:0]               qsh_ff, qsh_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_BITS-1:0] pixel_x_ff, pixel_x_in;
   logic signed [COORD_BITS-1:0] pixel_y_ff, pixel_y_in;
   logic                        last_ff, last_in;

   // combinational helpers
   logic                        out_free;
   logic                        req_fire;
   logic signed [COORD_BITS:0]  dx, dy;
   logic [COORD_BITS:0]         adx_w, ady_w;
   logic [COORD_BITS-1:0]       adx, ady;
   logic [COORD_BITS:0]         trial;
   logic [COORD_BITS+1:0]       diff;
   logic                        ge;
   logic [QW-1:0]               quo;
   logic signed [SW-1:0]        step_val;
   logic signed [AW-1:0]        x_next, y_next;

   // round to nearest: trunc_toward_zero(acc + half)
   function automatic logic [COORD_BITS-1:0] round_coord(input logic [AW-1:0] acc);
      logic [COORD_BITS:0] ip;
      logic [COORD_BITS:0] fl;
      logic                half_exact;
      logic [COORD_BITS:0] r;
      ip         = acc[AW-1:FRAC_BITS];
      half_exact = (acc[FRAC_BITS-1:0] == {1'b1, {(FRAC_BITS-1){1'b0}}});
      fl         = ip + {{COORD_BITS{1'b0}}, acc[FRAC_BITS-1]};
      r          = fl + {{COORD_BITS{1'b0}}, (fl[COORD_BITS] & ~half_exact)};
      return r[COORD_BITS-1:0];
   endfunction

   // handshake
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && out_free;
   assign req_fire       = req_chan.valid && req_chan.ready;

   // endpoint deltas and magnitudes
   assign dx    = {req_chan.x_end[COORD_BITS-1], req_chan.x_end}
                - {req_chan.x_start[COORD_BITS-1], req_chan.x_start};
   assign dy    = {req_chan.y_end[COORD_BITS-1], req_chan.y_end}
                - {req_chan.y_start[COORD_BITS-1], req_chan.y_start};
   assign adx_w = dx[COORD_BITS] ? -dx : dx;
   assign ady_w = dy[COORD_BITS] ? -dy : dy;
   assign adx   = adx_w[COORD_BITS-1:0];
   assign ady   = ady_w[COORD_BITS-1:0];

   // shared restoring divide step
   assign trial = {rem_ff, qsh_ff[QW-1]};
   assign diff  = {1'b0, trial} - {2'b00, steps_ff};
   assign ge    = !diff[COORD_BITS+1];
   assign quo   = {qsh_ff[QW-2:0], ge};

   // signed increment from the finished quotient, zero for a single pixel line
   always_comb begin
      logic signed [SW-1:0] q_ext;
      logic                 neg;
      q_ext = {1'b0, quo};
      neg   = axis_ff ? y_neg_ff : x_neg_ff;
      if (steps_ff == '0) begin
         step_val = '0;
      end else begin
         step_val = neg ? -q_ext : q_ext;
      end
   end

   // accumulator advance
   assign x_next = x_accum_ff + {{(AW-SW){x_step_ff[SW-1]}}, x_step_ff};
   assign y_next = y_accum_ff + {{(AW-SW){y_step_ff[SW-1]}}, y_step_ff};

   // sequencer and datapath next state
   always_comb begin
      state_in       = state_ff;
      x_accum_in     = x_accum_ff;
      y_accum_in     = y_accum_ff;
      x_step_in      = x_step_ff;
      y_step_in      = y_step_ff;
      pixels_left_in = pixels_left_ff;
      line_active_in = line_active_ff;
      steps_in       = steps_ff;
      ady_in         = ady_ff;
      x_neg_in       = x_neg_ff;
      y_neg_in       = y_neg_ff;
      axis_in        = axis_ff;
      cnt_in         = cnt_ff;
      rem_in         = rem_ff;
      qsh_in         = qsh_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      pixel_x_in     = pixel_x_ff;
      pixel_y_in     = pixel_y_ff;
      last_in        = last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_chan.func == FUNC_LOAD)) begin
               // load: start position, set up the x divide
               x_accum_in = {req_chan.x_start[COORD_BITS-1], req_chan.x_start,
                             {FRAC_BITS{1'b0}}};
               y_accum_in = {req_chan.y_start[COORD_BITS-1], req_chan.y_start,
                             {FRAC_BITS{1'b0}}};
               steps_in   = (adx > ady) ? adx : ady;
               ady_in     = ady;
               x_neg_in   = dx[COORD_BITS];
               y_neg_in   = dy[COORD_BITS];
               axis_in    = 1'b0;
               cnt_in     = '0;
               rem_in     = {1'b0, adx[COORD_BITS-1:1]};
               qsh_in     = {adx[0], {FRAC_BITS{1'b0}}};
               state_in   = ST_DIV;
            end else if (req_fire && line_active_ff) begin
               // advance: next pixel of the active line
               x_accum_in     = x_next;
               y_accum_in     = y_next;
               pixels_left_in = pixels_left_ff - 1'b1;
               line_active_in = (pixels_left_ff != {{COORD_BITS{1'b0}}, 1'b1});
               pixel_x_in     = round_coord(x_next);
               pixel_y_in     = round_coord(y_next);
               last_in        = (pixels_left_ff == {{COORD_BITS{1'b0}}, 1'b1});
               rsp_valid_in   = 1'b1;
            end
         end
         ST_DIV: begin
            rem_in = ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
            qsh_in = quo;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               cnt_in = '0;
               if (!axis_ff) begin
                  // x done, start the y divide
                  x_step_in = step_val;
                  axis_in   = 1'b1;
                  rem_in    = {1'b0, ady_ff[COORD_BITS-1:1]};
                  qsh_in    = {ady_ff[0], {FRAC_BITS{1'b0}}};
               end else begin
                  y_step_in = step_val;
                  state_in  = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            // first pixel of the new line once the output register is free
            if (out_free) begin
               pixel_x_in     = round_coord(x_accum_ff);
               pixel_y_in     = round_coord(y_accum_ff);
               last_in        = (steps_ff == '0);
               pixels_left_in = {1'b0, steps_ff};
               line_active_in = (steps_ff != '0);
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         x_accum_ff     <= '0;
         y_accum_ff     <= '0;
         x_step_ff      <= '0;
         y_step_ff      <= '0;
         pixels_left_ff <= '0;
         line_active_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         axis_ff        <= 1'b0;
         cnt_ff         <= '0;
      end else begin
         state_ff       <= state_in;
         x_accum_ff     <= x_accum_in;
         y_accum_ff     <= y_accum_in;
         x_step_ff      <= x_step_in;
         y_step_ff      <= y_step_in;
         pixels_left_ff <= pixels_left_in;
         line_active_ff <= line_active_in;
         rsp_valid_ff   <= rsp_valid_in;
         axis_ff        <= axis_in;
         cnt_ff         <= cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      steps_ff   <= steps_in;
      ady_ff     <= ady_in;
      x_neg_ff   <= x_neg_in;
      y_neg_ff   <= y_neg_in;
      rem_ff     <= rem_in;
      qsh_ff     <= qsh_in;
      pixel_x_ff <= pixel_x_in;
      pixel_y_ff <= pixel_y_in;
      last_ff    <= last_in;
   end

   // response outputs
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.pixel_x = pixel_x_ff;
   assign rsp_chan.pixel_y = pixel_y_ff;
   assign rsp_chan.last    = last_ff;

   // checks
   `DDA_ASSERT(a_idle_no_pixels, clock, reset,
      !line_active_ff |-> (pixels_left_ff == '0), "inactive line with pixels left")
   `DDA_ASSERT(a_last_ends_line, clock, reset,
      (rsp_valid_ff && last_ff) |-> !line_active_ff, "last pixel pending on active line")
   `DDA_ASSERT(a_step_range, clock, reset,
      (x_step_ff <= $signed({2'b01, {FRAC_BITS{1'b0}}}))
      && (x_step_ff >= -$signed({2'b01, {FRAC_BITS{1'b0}}}))
      && (y_step_ff <= $signed({2'b01, {FRAC_BITS{1'b0}}}))
      && (y_step_ff >= -$signed({2'b01, {FRAC_BITS{1'b0}}})),
      "increment beyond one pixel")

endmodule
